>>> rtl/prf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types and constants for the prefetch reward FIFO.
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP_W    = 5;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ADDR_W   = 32;
    localparam int STATE_W  = 16;
    localparam int OFFSET_W = 6;

    localparam int IN_DATA_W  = ((ADDR_W + STATE_W + OFFSET_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATE_W + OFFSET_W + 1 + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [0:0]
    {
        CMD_ISSUE = 1'b0,
        CMD_HIT   = 1'b1
    } prf_cmd_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]   address;
        logic [STATE_W-1:0]  state;
        logic [OFFSET_W-1:0] offset;
        logic                hit;
    } prf_entry_t;

    typedef struct packed
    {
        logic shift;    // take the neighbor's entry
        logic load;     // take the incoming entry
        logic set_hit;  // mark this entry as hit
    } prf_cell_ctrl_t;

endpackage

>>> rtl/prf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_cell
// One FIFO slot: holds an entry, compares it against the lookup address and
// takes its upper neighbor's entry when the queue advances.
// ----------------------------------------------------------------------------
module prf_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  prf_pkg::prf_cell_ctrl_t      ctrl,
    input  prf_pkg::prf_entry_t          neighbor,
    input  prf_pkg::prf_entry_t          incoming,
    input  logic [prf_pkg::ADDR_W-1:0]   lookup_address,
    output prf_pkg::prf_entry_t          entry,
    output logic                         match
);

    prf_pkg::prf_entry_t data_reg;
    prf_pkg::prf_entry_t data_next;
    logic                hit_reg;
    logic                hit_next;

    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        if (ctrl.load)
        begin
            data_next = incoming;
            hit_next  = 1'b0;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor;
            hit_next  = neighbor.hit;
        end
        else if (ctrl.set_hit)
        begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_comb
    begin
        entry     = data_reg;
        entry.hit = hit_reg;
    end

    assign match = (data_reg.address == lookup_address);

endmodule

>>> rtl/prefetch_reward_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefetch_reward_fifo_core
// Associative FIFO of issued prefetches with reward reporting on eviction.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle, issue or cache hit alike, whenever the
// output register is free or being drained: the address is compared against
// all sixteen slots in the same cycle and the queue shifts by one slot on an
// eviction; an eviction result is on m_tvalid in the cycle after its input
// beat. The oldest entry always sits in cell 0; the capacity register (0
// acts as 1, values above 16 as 16) is written on the cfg channel, which is
// always ready. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module prefetch_reward_fifo_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // block_address, state_id, prefetch_offset, zero pad
    input  logic [prf_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // evicted_state, evicted_offset, reward, zero pad
    output logic [prf_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prf_pkg::CAP_W-1:0]          cfg_data
);

    localparam int DEPTH = prf_pkg::DEPTH;
    localparam int CNT_W = prf_pkg::CNT_W;
    localparam int CMP_W = prf_pkg::CMP_W;

    logic [prf_pkg::CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [prf_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [prf_pkg::OUT_DATA_W-1:0] out_data_next;

    prf_pkg::prf_entry_t       incoming;
    prf_pkg::prf_entry_t       cell_entry [DEPTH];
    prf_pkg::prf_cell_ctrl_t   cell_ctrl  [DEPTH];
    logic [DEPTH-1:0]          cell_match;
    logic [DEPTH-1:0]          live_match;

    logic                      s_beat;
    logic                      is_issue;
    logic                      is_hit;
    logic                      duplicate;
    logic                      append;
    logic                      evict;
    logic [CMP_W-1:0]          eff_capacity;
    logic [CNT_W-1:0]          write_pos;

    assign s_beat   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign is_issue = (prf_pkg::prf_cmd_t'(s_tuser[0]) == prf_pkg::CMD_ISSUE);
    assign is_hit   = (prf_pkg::prf_cmd_t'(s_tuser[0]) == prf_pkg::CMD_HIT);

    assign incoming.address = s_tdata[prf_pkg::ADDR_W-1:0];
    assign incoming.state   = s_tdata[prf_pkg::ADDR_W +: prf_pkg::STATE_W];
    assign incoming.offset  =
        s_tdata[prf_pkg::ADDR_W + prf_pkg::STATE_W +: prf_pkg::OFFSET_W];
    assign incoming.hit     = 1'b0;

    // Clamp capacity into 1..DEPTH.
    always_comb
    begin
        eff_capacity = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            eff_capacity = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(DEPTH))
        begin
            eff_capacity = CMP_W'(DEPTH);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            prf_pkg::prf_entry_t neighbor;

            if (gi == DEPTH - 1)
            begin : g_tail
                assign neighbor = incoming;
            end
            else
            begin : g_body
                assign neighbor = cell_entry[gi+1];
            end

            assign live_match[gi] = cell_match[gi] && (CNT_W'(gi) < count_reg);

            assign cell_ctrl[gi].shift   = s_beat && append && evict;
            assign cell_ctrl[gi].load    = s_beat && append && (CNT_W'(gi) == write_pos);
            assign cell_ctrl[gi].set_hit = s_beat && is_hit && live_match[gi];

            prf_cell u_cell
            (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (cell_ctrl[gi]),
                .neighbor       (neighbor),
                .incoming       (incoming),
                .lookup_address (incoming.address),
                .entry          (cell_entry[gi]),
                .match          (cell_match[gi])
            );
        end
    endgenerate

    assign duplicate = |live_match;
    assign append    = is_issue && !duplicate;
    assign evict     = (CMP_W'(count_reg) >= eff_capacity) && (count_reg != '0);
    assign write_pos = evict ? (count_reg - CNT_W'(1)) : count_reg;

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s_beat && append)
        begin
            if (evict)
            begin
                out_valid_next = 1'b1;
                out_data_next  = prf_pkg::OUT_DATA_W'({cell_entry[0].hit,
                                                      cell_entry[0].offset,
                                                      cell_entry[0].state});
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= prf_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // Live entries never exceed the slot count.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("live count exceeds depth");

    // A cache-hit beat never changes the live count.
    a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && is_hit) |=> $stable(count_reg))
        else $error("hit beat changed live count");

    // A duplicate issue leaves the queue untouched.
    a_dup_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && is_issue && duplicate) |=> $stable(count_reg))
        else $error("duplicate issue changed live count");

    // An accepted new issue always leaves at least one live entry.
    a_append_live: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && append) |=> (count_reg != '0))
        else $error("queue empty after append");

    // Addresses in the live part of the queue are unique.
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live_match))
        else $error("address held by more than one live entry");

endmodule
